[rtl/lfcr_pkg.sv]
// ----------------------------------------------------------------------------
// lfcr_pkg
// Shared types, constants and the CRC-32 byte step for the length-framed
// CRC-32 receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package lfcr_pkg;

  // Field widths fixed by the frame format.
  localparam int POS_W = 16;
  localparam int LEN_W = 32;
  localparam int CRC_W = 32;

  // Header layout: length lanes at bytes 3 to 6, payload from byte 7.
  localparam int HDR_LEN_START = 3;
  localparam int HDR_TOTAL     = 7;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Request type codes on the input channel.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_DONE = 1'b1;

  // Command classes passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_LEN,
    CMD_DATA,
    CMD_DONE
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [1:0]       lane;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             hdr_short;
  } cmd_t;

  // One byte through the reflected CRC-32, eight bit steps.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0]       b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/lfcr_if.sv]
// ----------------------------------------------------------------------------
// lfcr_if
// Valid/ready channel interfaces for the receiver's byte input and its
// frame result output.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfcr_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface lfcr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] payload_length;
  logic [31:0] crc_value;
  logic        frame_short;
  logic        length_too_large;
  logic [15:0] bytes_received;

  modport source (output valid, output payload_length, output crc_value,
                  output frame_short, output length_too_large,
                  output bytes_received, input ready);
  modport sink   (input valid, input payload_length, input crc_value,
                  input frame_short, input length_too_large,
                  input bytes_received, output ready);
endinterface

`default_nettype wire

[rtl/lfcr_front.sv]
// ----------------------------------------------------------------------------
// lfcr_front
// Front end: tracks the byte position in the transfer and classifies each
// request as a length lane, a payload byte, a dropped byte or a done marker.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcr_front
  import lfcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 32768
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lfcr_in_if.sink    in_ch,
  input  wire logic  q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  localparam logic [POS_W-1:0] BUF_LIM   = POS_W'(BUFFER_BYTES);
  localparam logic [POS_W-1:0] LEN_START = POS_W'(HDR_LEN_START);
  localparam logic [POS_W-1:0] PAY_START = POS_W'(HDR_TOTAL);

  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             take;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  // Classify the accepted request and advance the position.
  always_comb begin
    pos_nxt         = pos_r;
    q_push          = 1'b0;
    q_cmd.op        = CMD_DATA;
    q_cmd.lane      = 2'(pos_r - LEN_START);
    q_cmd.data      = in_ch.rx_byte;
    q_cmd.pos       = pos_r;
    q_cmd.hdr_short = (pos_r < PAY_START);
    if (take) begin
      if (in_ch.req_type == REQ_DONE) begin
        q_push   = 1'b1;
        q_cmd.op = CMD_DONE;
        pos_nxt  = '0;
      end else if (pos_r < BUF_LIM) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r >= PAY_START) begin
          q_push   = 1'b1;
          q_cmd.op = CMD_DATA;
        end else if (pos_r >= LEN_START) begin
          q_push   = 1'b1;
          q_cmd.op = CMD_LEN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // The position never runs past the buffer size.
  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= BUF_LIM) else $error("byte position beyond buffer size");

  // A done request restarts the transfer at byte zero.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_ch.req_type == REQ_DONE) |=> (pos_r == '0))
    else $error("position not cleared after transfer done");

endmodule

`default_nettype wire

[rtl/lfcr_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// lfcr_cmd_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcr_cmd_fifo
  import lfcr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t       mem [2];
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_cmd   = mem[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Occupancy after this cycle's push and pop.
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("command queue overflow");

endmodule

`default_nettype wire

[rtl/lfcr_back.sv]
// ----------------------------------------------------------------------------
// lfcr_back
// Back end: assembles the length, runs the CRC over payload bytes and
// builds the frame result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfcr_back
  import lfcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 32768
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  cmd_valid,
  input  wire cmd_t  cmd,
  output logic       cmd_pop,
  lfcr_out_if.source out_ch
);

  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(BUFFER_BYTES - HDR_TOTAL);

  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [CRC_W-1:0] crc_r;
  logic [CRC_W-1:0] crc_nxt;
  logic [POS_W-1:0] cnt_r;
  logic [POS_W-1:0] cnt_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             cnt_below;
  logic             load_out;

  assign cnt_below = ({{(LEN_W-POS_W){1'b0}}, cnt_r} < len_r);

  // A done command waits until the output register is free.
  assign cmd_pop = cmd_valid &&
                   ((cmd.op != CMD_DONE) || !out_valid_r || out_ch.ready);

  // Length, CRC and count update per command.
  always_comb begin
    len_nxt       = len_r;
    crc_nxt       = crc_r;
    cnt_nxt       = cnt_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (cmd_pop) begin
      unique case (cmd.op)
        CMD_LEN: begin
          unique case (cmd.lane)
            2'd0:    len_nxt[7:0]   = cmd.data;
            2'd1:    len_nxt[15:8]  = cmd.data;
            2'd2:    len_nxt[23:16] = cmd.data;
            default: len_nxt[31:24] = cmd.data;
          endcase
        end
        CMD_DATA: begin
          if (cnt_below) begin
            crc_nxt = crc_feed(crc_r, cmd.data);
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        CMD_DONE: begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          len_nxt       = '0;
          crc_nxt       = CRC_INIT;
          cnt_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      crc_r       <= CRC_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      crc_r       <= crc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.payload_length   <= len_r;
      out_ch.crc_value        <= ~crc_r;
      out_ch.frame_short      <= cmd.hdr_short || cnt_below;
      out_ch.length_too_large <= (len_r > LEN_CAP);
      out_ch.bytes_received   <= cmd.pos;
    end
  end

  assign out_ch.valid = out_valid_r;

  // Payload bytes counted never exceed the stated length.
  a_cnt_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    {{(LEN_W-POS_W){1'b0}}, cnt_r} <= len_r)
    else $error("payload count beyond length");

  // A finished frame leaves the back end cleared for the next transfer.
  a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.op == CMD_DONE) |=>
      (crc_r == CRC_INIT && len_r == '0 && cnt_r == '0 && out_valid_r))
    else $error("back end not cleared after done");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !load_out)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[rtl/length_framed_crc32_receiver_unit.sv]
// ----------------------------------------------------------------------------
// length_framed_crc32_receiver_unit
// Byte-serial frame receiver with a 32-bit length header and CRC-32 check.
// ----------------------------------------------------------------------------
// The unit takes one request per cycle while the command queue is not full:
// a received byte or a transfer-done marker. Up to BUFFER_BYTES bytes per
// transfer are kept; bytes 3 to 6 form a little-endian payload length and
// payload bytes from byte 7 feed a reflected CRC-32 until the length is
// reached. A done request goes through the queue and yields one result,
// carrying the length, the inverted CRC, the short-frame and oversize flags
// and the kept byte count, and clears the unit for the next transfer. The
// eight-step CRC byte update is combinational in the back end; a two-entry
// command queue and the output register let input and output stall apart.
// ----------------------------------------------------------------------------
`default_nettype none

module length_framed_crc32_receiver_unit
  import lfcr_pkg::*;
#(
  parameter int BUFFER_BYTES = 32768
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lfcr_in_if.sink    in_ch,
  lfcr_out_if.source out_ch
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_head;

  lfcr_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  lfcr_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  lfcr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
